FILE: hw/rtl/pcl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcl_pkg
// types and codes shared by the positional circular list cells and top level
// ----------------------------------------------------------------------------
package pcl_pkg;

    localparam int WORD_W  = 32;
    localparam int IDX_W   = 8;
    localparam int CNT_OUT_W = 5;

    // operation codes
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_INS_POS   = 3'd2;
    localparam logic [2:0] OP_DEL_FRONT = 3'd3;
    localparam logic [2:0] OP_DEL_POS   = 3'd4;
    localparam logic [2:0] OP_DEL_BACK  = 3'd5;
    localparam logic [2:0] OP_READ      = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // cell shift operations
    localparam logic [1:0] SH_HOLD = 2'd0;
    localparam logic [1:0] SH_INS  = 2'd1;
    localparam logic [1:0] SH_DEL  = 2'd2;
    localparam logic [1:0] SH_ROT  = 2'd3;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [WORD_W-1:0] value;
        logic [7:0]               position;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] entry_value;
        logic                     is_last;
        logic [CNT_OUT_W-1:0]     entry_count;
    } t_out;

    typedef struct packed {
        logic [1:0]        shift_op;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  last;
        logic [WORD_W-1:0] word;
    } t_cell_cmd;

endpackage
`default_nettype wire

FILE: hw/rtl/pcl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcl_cell
// one list entry; takes its word from itself, a neighbor, the head or the bus
// ----------------------------------------------------------------------------
module pcl_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                      i_clk,
    input  wire pcl_pkg::t_cell_cmd        i_cmd,
    input  wire logic [pcl_pkg::WORD_W-1:0] i_left,
    input  wire logic [pcl_pkg::WORD_W-1:0] i_right,
    input  wire logic [pcl_pkg::WORD_W-1:0] i_head,
    output logic      [pcl_pkg::WORD_W-1:0] o_word
);

    localparam logic [pcl_pkg::IDX_W-1:0] MY_IDX = pcl_pkg::IDX_W'(CELL_IDX);

    logic [pcl_pkg::WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        case (i_cmd.shift_op)
            pcl_pkg::SH_INS: begin
                if (MY_IDX == i_cmd.idx) begin
                    r_word <= i_cmd.word;
                end else if (MY_IDX > i_cmd.idx) begin
                    r_word <= i_left;
                end
            end
            pcl_pkg::SH_DEL: begin
                if (MY_IDX >= i_cmd.idx) begin
                    r_word <= i_right;
                end
            end
            pcl_pkg::SH_ROT: begin
                // rotate within the occupied cells only
                if (MY_IDX == i_cmd.last) begin
                    r_word <= i_head;
                end else if (MY_IDX < i_cmd.last) begin
                    r_word <= i_right;
                end
            end
            default: begin
                r_word <= r_word;
            end
        endcase
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

FILE: hw/rtl/pcl_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcl_chain
// row of entry cells wired to their neighbors, front of the list at cell 0
// ----------------------------------------------------------------------------
module pcl_chain #(
    parameter int CAPACITY = 16
) (
    input  wire logic                       i_clk,
    input  wire pcl_pkg::t_cell_cmd         i_cmd,
    output logic      [pcl_pkg::WORD_W-1:0] o_head
);

    logic [pcl_pkg::WORD_W-1:0] w_word [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [pcl_pkg::WORD_W-1:0] w_left;
        logic [pcl_pkg::WORD_W-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = i_cmd.word;
        end else begin : g_mid_l
            assign w_left = w_word[k-1];
        end

        if (k == CAPACITY - 1) begin : g_lastc
            assign w_right = w_word[k];
        end else begin : g_mid_r
            assign w_right = w_word[k+1];
        end

        pcl_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_word[0]),
            .o_word  (w_word[k])
        );
    end

    assign o_head = w_word[0];

endmodule
`default_nettype wire

FILE: hw/rtl/positional_circular_list_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_circular_list_top
// ordered list of signed words in a chain of cells with insert, delete and
// in-order read-out at front, back or a 1-based position
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                payload
//  -------   ---  -----------------------  -------------------------------
//  in        in   i_in_valid / o_in_stall  i_in  (opcode, value, position)
//  out       out  o_out_valid / i_out_stall o_out (status, entry_value,
//                                                 is_last, entry_count)
//
//  an insert, delete or status-only transaction is first captured, then
//  decided, with every cell shifted at once in the deciding step
//  a read-out is captured and decided, then emits its entries front first,
//  as the chain rotation brings each entry to cell 0 in turn
//  reset clears the entry count and control; cell contents need no clearing
//  a stall on the out channel holds the controller until the output register
//  can take the next result; the input is stalled while a transaction is open
// ----------------------------------------------------------------------------
module positional_circular_list_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire pcl_pkg::t_in   i_in,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output pcl_pkg::t_out       o_out,
    input  wire logic           i_out_stall
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

    // controller states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]         r_state,     n_state;
    logic [CW-1:0]      r_count,     n_count;
    logic [IW-1:0]      r_rd_idx,    n_rd_idx;
    logic               r_out_valid, n_out_valid;
    pcl_pkg::t_out      r_out,       n_out;
    pcl_pkg::t_in       r_cmd;

    pcl_pkg::t_cell_cmd w_cell_cmd;
    logic [pcl_pkg::WORD_W-1:0] w_head;

    logic               w_out_free;
    logic               w_in_acc;
    logic               w_is_ins;
    logic               w_is_del;
    logic               w_full;
    logic               w_empty;
    logic               w_ins_bad;
    logic               w_del_bad;
    logic               w_rd_last;
    logic [CMPW-1:0]    w_pos_x;
    logic [CMPW-1:0]    w_cnt_x;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    // the output register can load when empty or being drained this cycle
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_is_ins = (r_cmd.opcode == pcl_pkg::OP_INS_FRONT) ||
                      (r_cmd.opcode == pcl_pkg::OP_INS_BACK)  ||
                      (r_cmd.opcode == pcl_pkg::OP_INS_POS);
    assign w_is_del = (r_cmd.opcode == pcl_pkg::OP_DEL_FRONT) ||
                      (r_cmd.opcode == pcl_pkg::OP_DEL_POS)   ||
                      (r_cmd.opcode == pcl_pkg::OP_DEL_BACK);

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);

    // position checks widened so a full 8-bit position never wraps
    assign w_pos_x   = CMPW'(r_cmd.position);
    assign w_cnt_x   = CMPW'(r_count);
    assign w_ins_bad = (r_cmd.position == 8'd0) || (w_pos_x > (w_cnt_x + CMPW'(1)));
    assign w_del_bad = (r_cmd.position == 8'd0) || (w_pos_x > w_cnt_x);

    assign w_rd_last = (CW'(r_rd_idx) == (r_count - CW'(1)));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        w_cell_cmd.shift_op = pcl_pkg::SH_HOLD;
        w_cell_cmd.idx      = '0;
        w_cell_cmd.last     = pcl_pkg::IDX_W'(r_count - CW'(1));
        w_cell_cmd.word     = r_cmd.value;

        // a taken result leaves the output register
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (w_in_acc) begin
            n_state = S_EXEC;
        end

        case (r_state)
            S_EXEC: begin
                if (w_out_free) begin
                    n_out.status      = pcl_pkg::ST_OK;
                    n_out.entry_value = '0;
                    n_out.is_last     = 1'b1;
                    n_state           = S_IDLE;
                    n_out_valid       = 1'b1;

                    if (w_is_ins) begin
                        // full takes precedence over a bad position
                        if (w_full) begin
                            n_out.status = pcl_pkg::ST_FULL;
                        end else if ((r_cmd.opcode == pcl_pkg::OP_INS_POS) && w_ins_bad) begin
                            n_out.status = pcl_pkg::ST_BADPOS;
                        end else begin
                            w_cell_cmd.shift_op = pcl_pkg::SH_INS;
                            case (r_cmd.opcode)
                                pcl_pkg::OP_INS_FRONT: w_cell_cmd.idx = '0;
                                pcl_pkg::OP_INS_BACK:
                                    w_cell_cmd.idx = pcl_pkg::IDX_W'(r_count);
                                default:
                                    w_cell_cmd.idx = r_cmd.position - 8'd1;
                            endcase
                            n_count = r_count + CW'(1);
                        end
                    end else if (w_is_del) begin
                        // empty takes precedence over a bad position
                        if (w_empty) begin
                            n_out.status = pcl_pkg::ST_EMPTY;
                        end else if ((r_cmd.opcode == pcl_pkg::OP_DEL_POS) && w_del_bad) begin
                            n_out.status = pcl_pkg::ST_BADPOS;
                        end else begin
                            w_cell_cmd.shift_op = pcl_pkg::SH_DEL;
                            case (r_cmd.opcode)
                                pcl_pkg::OP_DEL_FRONT: w_cell_cmd.idx = '0;
                                pcl_pkg::OP_DEL_BACK:
                                    w_cell_cmd.idx = pcl_pkg::IDX_W'(r_count - CW'(1));
                                default:
                                    w_cell_cmd.idx = r_cmd.position - 8'd1;
                            endcase
                            n_count = r_count - CW'(1);
                        end
                    end else if (r_cmd.opcode == pcl_pkg::OP_READ) begin
                        if (w_empty) begin
                            n_out.status = pcl_pkg::ST_EMPTY;
                        end else begin
                            // no result yet, the read-out loop emits them
                            n_out_valid = !i_out_stall ? 1'b0 : r_out_valid;
                            n_out       = r_out;
                            n_state     = S_READ;
                            n_rd_idx    = '0;
                        end
                    end

                    if (n_state == S_IDLE) begin
                        n_out.entry_count = pcl_pkg::CNT_OUT_W'(n_count);
                    end
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    // emit cell 0, then rotate the occupied cells by one
                    n_out.status        = pcl_pkg::ST_OK;
                    n_out.entry_value   = $signed(w_head);
                    n_out.is_last       = w_rd_last;
                    n_out.entry_count   = pcl_pkg::CNT_OUT_W'(r_count);
                    n_out_valid         = 1'b1;
                    w_cell_cmd.shift_op = pcl_pkg::SH_ROT;
                    n_rd_idx            = r_rd_idx + IW'(1);
                    if (w_rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = n_state;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_in_acc) begin
            r_cmd <= i_in;
        end
    end

    pcl_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .i_clk  (i_clk),
        .i_cmd  (w_cell_cmd),
        .o_head (w_head)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

FILE: tb/tb_positional_circular_list_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_circular_list_top
// checks the positional circular list against its own list model: every
// accepted transaction updates a model of the cells and queues the results it
// must produce, and each result leaving the block is compared field by field
// with the oldest queued one; directed edge cases come first, then random
// traffic with gaps and stalls on both channels and one long output hold-off
// ----------------------------------------------------------------------------
module tb_positional_circular_list_top;

    localparam int LIST_CAP = 16;
    // opcode that the block treats as a no-op
    localparam logic [2:0] OP_UNUSED = 3'd7;
    // cycles the receiver holds off in the pressure test
    localparam int HOLD_CYCLES = 80;
    // cycles to wait for stray results at the end
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS = 40;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    pcl_pkg::t_in  i_in        = '0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    pcl_pkg::t_out o_out;

    // list model: cell 0 is the front
    logic signed [pcl_pkg::WORD_W-1:0] list_cells [LIST_CAP];
    int   list_count = 0;
    pcl_pkg::t_out expected_results [$];

    int fail_count   = 0;
    int result_index = 0;

    // traffic shaping knobs, set by the test tasks
    bit sender_gaps_on = 1'b0;
    bit stall_gaps_on  = 1'b0;
    bit hold_request   = 1'b0;
    bit growing        = 1'b1;

    positional_circular_list_top #(
        .CAPACITY(LIST_CAP)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_stall(i_out_stall)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic pcl_pkg::t_in make_item(logic [2:0] op, logic [31:0] word, int pos);
        pcl_pkg::t_in item;
        item.opcode   = op;
        item.value    = word;
        item.position = pos[7:0];
        return item;
    endfunction

    // word with a bias toward the signed extremes, zero and minus one
    function automatic logic [31:0] random_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h8000_0000;
        if (r == 1) return 32'h7fff_ffff;
        if (r == 2) return 32'h0000_0000;
        if (r == 3) return 32'hffff_ffff;
        return $urandom();
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("mismatch at %0t ns, result %0d: %s", $time, result_index, msg);
    endtask

    // ------------------------------------------------------------------------
    // list model: applies one transaction and queues the results it causes
    // ------------------------------------------------------------------------
    task automatic predict_list_op(input pcl_pkg::t_in item);
        pcl_pkg::t_out res;
        logic [1:0]    status;
        int            slot;
        int            k;
        int            pos;
        res    = '0;
        status = pcl_pkg::ST_OK;
        slot   = -1;
        pos    = int'(item.position);
        case (item.opcode)
            pcl_pkg::OP_INS_FRONT, pcl_pkg::OP_INS_BACK, pcl_pkg::OP_INS_POS: begin
                // full check wins over the position check
                if (list_count >= LIST_CAP) begin
                    status = pcl_pkg::ST_FULL;
                end else begin
                    if (item.opcode == pcl_pkg::OP_INS_FRONT) slot = 0;
                    else if (item.opcode == pcl_pkg::OP_INS_BACK) slot = list_count;
                    else if (pos >= 1 && pos <= list_count + 1) slot = pos - 1;
                    if (slot < 0) begin
                        status = pcl_pkg::ST_BADPOS;
                    end else begin
                        for (k = list_count; k > slot; k--) list_cells[k] = list_cells[k-1];
                        list_cells[slot] = item.value;
                        list_count++;
                    end
                end
            end
            pcl_pkg::OP_DEL_FRONT, pcl_pkg::OP_DEL_POS, pcl_pkg::OP_DEL_BACK: begin
                // empty check wins over the position check
                if (list_count == 0) begin
                    status = pcl_pkg::ST_EMPTY;
                end else begin
                    if (item.opcode == pcl_pkg::OP_DEL_FRONT) slot = 0;
                    else if (item.opcode == pcl_pkg::OP_DEL_BACK) slot = list_count - 1;
                    else if (pos >= 1 && pos <= list_count) slot = pos - 1;
                    if (slot < 0) begin
                        status = pcl_pkg::ST_BADPOS;
                    end else begin
                        for (k = slot; k < list_count - 1; k++) list_cells[k] = list_cells[k+1];
                        list_count--;
                    end
                end
            end
            pcl_pkg::OP_READ: begin
                if (list_count == 0) status = pcl_pkg::ST_EMPTY;
            end
            default: begin
                status = pcl_pkg::ST_OK;
            end
        endcase

        if (item.opcode == pcl_pkg::OP_READ && list_count > 0) begin
            // one result per entry, front first, last one marked
            for (k = 0; k < list_count; k++) begin
                res.status      = pcl_pkg::ST_OK;
                res.entry_value = list_cells[k];
                res.is_last     = (k == list_count - 1);
                res.entry_count = list_count[4:0];
                expected_results.push_back(res);
            end
        end else begin
            res.status      = status;
            res.entry_value = '0;
            res.is_last     = 1'b1;
            res.entry_count = list_count[4:0];
            expected_results.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------------
    // sender: one transaction on the in channel, valid stays high afterward
    // so that back-to-back items need no second assignment in one step
    // ------------------------------------------------------------------------
    task automatic send_item(input pcl_pkg::t_in item);
        int gap;
        gap = sender_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        predict_list_op(item);
    endtask

    // random transaction that mostly stays well formed, swinging the list
    // between empty and full so both ends get exercised
    function automatic pcl_pkg::t_in random_list_item();
        pcl_pkg::t_in item;
        int unsigned  r;
        int           cnt;
        bit           do_insert;
        cnt           = list_count;
        item.value    = random_word();
        item.position = 8'($urandom_range(0, 255));
        item.opcode   = pcl_pkg::OP_READ;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // noise: any opcode, any position
            item.opcode = 3'($urandom_range(0, 7));
            return item;
        end
        if (cnt >= LIST_CAP && $urandom_range(0, 2) != 0) growing = 1'b0;
        if (cnt == 0) growing = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 12) return item;
        do_insert = growing ? (r < 72) : (r >= 72);
        if (do_insert) begin
            case ($urandom_range(0, 2))
                0:       item.opcode = pcl_pkg::OP_INS_FRONT;
                1:       item.opcode = pcl_pkg::OP_INS_BACK;
                default: item.opcode = pcl_pkg::OP_INS_POS;
            endcase
            if ($urandom_range(0, 9) != 0) item.position = 8'($urandom_range(1, cnt + 1));
        end else begin
            case ($urandom_range(0, 2))
                0:       item.opcode = pcl_pkg::OP_DEL_FRONT;
                1:       item.opcode = pcl_pkg::OP_DEL_BACK;
                default: item.opcode = pcl_pkg::OP_DEL_POS;
            endcase
            if (cnt > 0 && $urandom_range(0, 9) != 0) item.position = 8'($urandom_range(1, cnt));
        end
        return item;
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    task automatic check_result(input pcl_pkg::t_out got);
        pcl_pkg::t_out want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", got));
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.entry_value !== want.entry_value)
            report_mismatch($sformatf("entry_value %0d, want %0d",
                                      got.entry_value, want.entry_value));
        if (got.is_last !== want.is_last)
            report_mismatch($sformatf("is_last %0b, want %0b", got.is_last, want.is_last));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      got.entry_count, want.entry_count));
    endtask

    // a result transaction happens on every edge with valid high and no stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_result(o_out);
            result_index++;
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall: random stalls, or one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_gaps_on) begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // every read and delete operation on an empty list, a no-op opcode included
    task automatic test_empty_list();
        send_item(make_item(pcl_pkg::OP_READ,      32'h0, 0));
        send_item(make_item(pcl_pkg::OP_DEL_FRONT, 32'h0, 1));
        send_item(make_item(pcl_pkg::OP_DEL_POS,   32'h0, 0));   // empty beats bad position
        send_item(make_item(pcl_pkg::OP_DEL_BACK,  32'h0, 255));
        send_item(make_item(OP_UNUSED,             32'hffff_ffff, 255));
    endtask

    // fill with every insert kind and the word extremes, then hit the full list
    task automatic test_fill_to_capacity();
        int k;
        send_item(make_item(pcl_pkg::OP_INS_BACK,  32'h8000_0000, 0));
        send_item(make_item(pcl_pkg::OP_INS_FRONT, 32'h7fff_ffff, 0));
        send_item(make_item(pcl_pkg::OP_INS_POS,   32'h0000_0000, 2));
        send_item(make_item(pcl_pkg::OP_INS_POS,   32'hffff_ffff, 4));   // one past the back
        for (k = 4; k < LIST_CAP; k++) begin
            case (k % 3)
                0:       send_item(make_item(pcl_pkg::OP_INS_FRONT, $urandom(), 0));
                1:       send_item(make_item(pcl_pkg::OP_INS_BACK,  $urandom(), 0));
                default: send_item(make_item(pcl_pkg::OP_INS_POS, $urandom(),
                                             $urandom_range(1, list_count + 1)));
            endcase
        end
        send_item(make_item(pcl_pkg::OP_INS_FRONT, 32'h1234_5678, 0));
        // full beats bad position
        send_item(make_item(pcl_pkg::OP_INS_POS,   32'h1234_5678, 0));
        send_item(make_item(pcl_pkg::OP_READ,      32'h0, 0));
    endtask

    // positions just outside the legal range, and at its edges
    task automatic test_bad_positions();
        send_item(make_item(pcl_pkg::OP_DEL_POS, 32'h0, 0));
        send_item(make_item(pcl_pkg::OP_DEL_POS, 32'h0, list_count + 1));
        send_item(make_item(pcl_pkg::OP_DEL_POS, 32'h0, list_count));
        send_item(make_item(pcl_pkg::OP_INS_POS, 32'h5a5a_5a5a, 255));
        send_item(make_item(pcl_pkg::OP_INS_POS, 32'h5a5a_5a5a, 0));
        send_item(make_item(pcl_pkg::OP_DEL_FRONT, 32'h0, 0));
        send_item(make_item(pcl_pkg::OP_DEL_BACK,  32'h0, 0));
        send_item(make_item(pcl_pkg::OP_INS_POS, 32'ha5a5_a5a5, list_count + 2));
    endtask

    // random traffic with gaps and stalls on both channels
    task automatic test_random_traffic(input int n);
        int k;
        sender_gaps_on = 1'b1;
        stall_gaps_on  = 1'b1;
        for (k = 0; k < n; k++) send_item(random_list_item());
    endtask

    // random traffic with neither side idling
    task automatic test_back_to_back(input int n);
        int k;
        sender_gaps_on = 1'b0;
        stall_gaps_on  = 1'b0;
        for (k = 0; k < n; k++) send_item(random_list_item());
    endtask

    // receiver holds off for a long stretch while transactions keep coming
    task automatic test_output_hold();
        int k;
        sender_gaps_on = 1'b0;
        stall_gaps_on  = 1'b0;
        hold_request   = 1'b1;
        send_item(make_item(pcl_pkg::OP_READ, 32'h0, 0));
        for (k = 0; k < 6; k++) send_item(random_list_item());
        send_item(make_item(pcl_pkg::OP_READ, 32'h0, 0));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_fill_to_capacity();
        test_bad_positions();
        test_random_traffic(50);
        test_back_to_back(30);
        test_output_hold();
        test_random_traffic(35);

        i_in_valid     <= 1'b0;
        stall_gaps_on  = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
